### src/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types, register indexes, reset timings, the saturating add and the
// initial state for the debounced long-press detector.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int unsigned TIME_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REARM_TIME    = 2'd2;

    localparam logic [TIME_W-1:0] RST_DEBOUNCE_TIME = 16'd50;
    localparam logic [TIME_W-1:0] RST_HOLD_TIME     = 16'd3000;
    localparam logic [TIME_W-1:0] RST_REARM_TIME    = 16'd1000;

    typedef logic [TIME_W-1:0] time_t;

    typedef struct packed {
        time_t debounce_time;
        time_t hold_time;
        time_t rearm_time;
    } cfg_t;

    typedef struct packed {
        logic  reinit;
        cfg_t  regs;
    } cfg_upd_t;

    typedef struct packed {
        logic  prev_raw;
        time_t stable_timer;
        logic  debounced;
        time_t press_timer;
        time_t release_timer;
        logic  fired_hold;
        logic  armed;
    } state_t;

    function automatic time_t sat_add(input time_t cur, input time_t inc, input time_t cap);
        logic [TIME_W:0] sum;
        time_t           res;
        sum = {1'b0, cur} + {1'b0, inc};
        if ((cur >= cap) || (sum >= {1'b0, cap}))
        begin
            res = cap;
        end
        else
        begin
            res = sum[TIME_W-1:0];
        end
        return res;
    endfunction

    function automatic state_t init_state(input cfg_t c);
        state_t s;
        s.prev_raw      = 1'b0;
        s.stable_timer  = c.debounce_time;
        s.debounced     = 1'b0;
        s.press_timer   = '0;
        s.release_timer = c.rearm_time;
        s.fired_hold    = 1'b0;
        s.armed         = 1'b1;
        return s;
    endfunction

endpackage

### src/button_debounce_long_press_detector_core.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_detector_core
// Debounced long-press detector: one fire flag per raw button sample.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_ready, raw_level,   | into block
//           | elapsed                          |
//   out     | out_valid, out_ready, fire       | out of block
//   cfg     | cfg_we, cfg_index, cfg_data      | into block
//
// One item per cycle unless the output stalls; fire is the result register.
// The state update is a single pass between the input and result registers.
// Reset loads the default timings and the idle detector state.
// A stalled output holds the result; the input register still takes one
// more item while the result waits.
// ----------------------------------------------------------------------------
module button_debounce_long_press_detector_core
    import bdlp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 raw_level,
    input  logic [TIME_W-1:0]    elapsed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 fire
);

    cfg_t     cfg;
    cfg_upd_t cfg_upd;

    logic  in_valid_reg;
    logic  raw_reg;
    time_t elapsed_reg;
    logic  out_valid_reg;
    logic  fire_reg;
    logic  fire_next;
    logic  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    bdlp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_upd   (cfg_upd)
    );

    bdlp_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_upd   (cfg_upd),
        .advance   (advance),
        .raw_level (raw_reg),
        .elapsed   (elapsed_reg),
        .fire_next (fire_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            raw_reg     <= raw_level;
            elapsed_reg <= elapsed;
        end
        if (advance)
        begin
            fire_reg <= fire_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fire      = fire_reg;

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("item dropped from input register while stalled");

    a_stall_keeps_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(fire_reg))
        else $error("held result changed");

endmodule

### src/bdlp_cfg.sv
// ----------------------------------------------------------------------------
// bdlp_cfg
// Configuration registers; flags a re-initialization on every write that
// hits a defined register.
// ----------------------------------------------------------------------------
module bdlp_cfg
    import bdlp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    output cfg_t                 cfg,
    output cfg_upd_t             cfg_upd
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic hit;

    always_comb
    begin
        cfg_next = cfg_reg;
        hit      = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TIME:
                begin
                    cfg_next.debounce_time = cfg_data;
                    hit                    = 1'b1;
                end
                REG_HOLD_TIME:
                begin
                    cfg_next.hold_time = cfg_data;
                    hit                = 1'b1;
                end
                REG_REARM_TIME:
                begin
                    cfg_next.rearm_time = cfg_data;
                    hit                 = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time <= RST_DEBOUNCE_TIME;
            cfg_reg.hold_time     <= RST_HOLD_TIME;
            cfg_reg.rearm_time    <= RST_REARM_TIME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg            = cfg_reg;
    assign cfg_upd.reinit = hit;
    assign cfg_upd.regs   = cfg_next;

endmodule

### src/bdlp_step.sv
// ----------------------------------------------------------------------------
// bdlp_step
// Detector state, its one-item update (debounce, hold and rearm timers) and
// its re-initialization on a configuration write.
module bdlp_step
    import bdlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cfg_upd_t    cfg_upd,
    input  logic        advance,
    input  logic        raw_level,
    input  time_t       elapsed,
    output logic        fire_next
);

    state_t state_reg;
    state_t state_next;
    state_t s;

    always_comb
    begin
        s         = state_reg;
        fire_next = 1'b0;

        if (raw_level != s.prev_raw)
        begin
            s.prev_raw     = raw_level;
            s.stable_timer = '0;
        end
        else
        begin
            s.stable_timer = sat_add(s.stable_timer, elapsed, cfg.debounce_time);
        end

        if ((s.stable_timer >= cfg.debounce_time) && (s.debounced != raw_level))
        begin
            s.debounced   = raw_level;
            s.press_timer = '0;
            if (raw_level)
            begin
                s.release_timer = '0;
                s.fired_hold    = 1'b0;
            end
        end

        if (s.debounced)
        begin
            s.release_timer = '0;
            s.press_timer   = sat_add(s.press_timer, elapsed, cfg.hold_time);
            if (s.armed && !s.fired_hold && (s.press_timer >= cfg.hold_time))
            begin
                s.fired_hold = 1'b1;
                s.armed      = 1'b0;
                fire_next    = 1'b1;
            end
        end
        else
        begin
            s.press_timer   = '0;
            s.release_timer = sat_add(s.release_timer, elapsed, cfg.rearm_time);
            if (!s.armed && (s.release_timer >= cfg.rearm_time))
            begin
                s.armed = 1'b1;
            end
        end

        if (cfg_upd.reinit)
        begin
            state_next = init_state(cfg_upd.regs);
        end
        else if (advance)
        begin
            state_next = s;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_raw      <= 1'b0;
            state_reg.stable_timer  <= RST_DEBOUNCE_TIME;
            state_reg.debounced     <= 1'b0;
            state_reg.press_timer   <= '0;
            state_reg.release_timer <= RST_REARM_TIME;
            state_reg.fired_hold    <= 1'b0;
            state_reg.armed         <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fire_next && !cfg_upd.reinit) |=> (!state_reg.armed && state_reg.fired_hold))
        else $error("fire did not disarm the detector");

    a_release_idle_when_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.debounced |-> (state_reg.release_timer == '0))
        else $error("release timer running while pressed");

    a_press_idle_when_released: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.debounced |-> (state_reg.press_timer == '0))
        else $error("press timer running while released");

    a_stable_capped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.stable_timer <= cfg.debounce_time)
        else $error("stability timer above debounce time");

endmodule
